### src/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted min priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int DEPTH = 32;
  localparam int KEY_W = 8;
  localparam int CAP_W = 6;
  localparam int OCC_W = 6;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_INSERTED     = 2'd0,
    ST_REMOVED      = 2'd1,
    ST_REFUSED_FULL = 2'd2,
    ST_REFUSED_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic       mode;
    key_t       key_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    key_t             key_out;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic remove;
    key_t key;
  } cell_ctl_t;

endpackage

### src/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded min priority queue of signed 8-bit keys held in a row of cells
// kept in ascending order, smallest key at the head.
// ----------------------------------------------------------------------------
//  port group     direction  handshake               payload
//  item           in         item_valid/item_stall   in_item_t
//  result         out        result_valid/result_stall out_item_t
//  cfg            in         cfg_we                  capacity
//
//  one item per cycle unless stalled; all cells compare to the key in parallel
//  result appears in the cycle after the item is taken, from an output register
//  an item is taken while the output register is empty or being drained
//  reset clears occupancy, capacity returns to 32; no clearing pass
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  smpq_pkg::in_item_t          item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output smpq_pkg::out_item_t         result,
  input  logic                        cfg_we,
  input  logic [smpq_pkg::CAP_W-1:0]  cfg_data
);

  logic [smpq_pkg::CAP_W-1:0] capacity;
  logic [smpq_pkg::CNT_W-1:0] count;
  logic [smpq_pkg::CNT_W-1:0] count_next;
  smpq_pkg::out_item_t        result_next;
  smpq_pkg::cell_ctl_t        ctl;
  smpq_pkg::key_t             keys [smpq_pkg::DEPTH];
  logic [smpq_pkg::DEPTH-1:0] gts;
  logic [smpq_pkg::DEPTH-1:0] occ;
  logic                       accept;
  logic                       full;
  logic                       empty;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign full  = (smpq_pkg::CMP_W'(count) >= smpq_pkg::CMP_W'(capacity)) ||
                 (count >= smpq_pkg::CNT_W'(smpq_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl.insert  = accept && (item.mode == smpq_pkg::MODE_INSERT) && !full;
    ctl.remove  = accept && (item.mode == smpq_pkg::MODE_REMOVE) && !empty;
    ctl.key     = item.key_in;
    count_next  = count;
    result_next.key_out = '0;
    if (item.mode == smpq_pkg::MODE_INSERT) begin
      if (full) begin
        result_next.status = smpq_pkg::ST_REFUSED_FULL;
      end else begin
        result_next.status = smpq_pkg::ST_INSERTED;
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        result_next.status = smpq_pkg::ST_REFUSED_EMPTY;
      end else begin
        result_next.status = smpq_pkg::ST_REMOVED;
        result_next.key_out = keys[0];
        count_next = count - 1'b1;
      end
    end
    result_next.occupancy = smpq_pkg::OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= smpq_pkg::CAP_RESET;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  for (genvar g = 0; g < smpq_pkg::DEPTH; g++) begin : g_cell
    smpq_pkg::key_t lk;
    smpq_pkg::key_t rk;
    logic           lg;

    assign occ[g] = (count > smpq_pkg::CNT_W'(g));

    if (g == 0) begin : g_head
      assign lk = item.key_in;
      assign lg = 1'b0;
    end else begin : g_body
      assign lk = keys[g-1];
      assign lg = gts[g-1];
    end

    if (g == smpq_pkg::DEPTH - 1) begin : g_tail
      assign rk = keys[g];
    end else begin : g_inner
      assign rk = keys[g+1];
    end

    smpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occ[g]),
      .left_key  (lk),
      .left_gt   (lg),
      .right_key (rk),
      .key       (keys[g]),
      .gt        (gts[g])
    );
  end

endmodule

### src/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted store: holds a key, shifts toward the head on
// remove and toward the tail on insert past a larger key.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic              clk,
  input  smpq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  smpq_pkg::key_t    left_key,
  input  logic              left_gt,
  input  smpq_pkg::key_t    right_key,
  output smpq_pkg::key_t    key,
  output logic              gt
);

  // empty slots count as larger than any key
  assign gt = !occupied || (key > ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.insert && gt) begin
      key <= left_gt ? left_key : ctl.key;
    end else if (ctl.remove) begin
      key <= right_key;
    end
  end

endmodule
